// ===== rtl/csb_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// csb_pkg: clock seven segment buffer package
// Buffer geometry, segment tables and the types shared across the block.
// ---------------------------------------------------------------------------
package csb_pkg;

   localparam int ROWS    = 4;                            // display rows, 1..8
   localparam int DIGITS  = 8;
   localparam int ENTRIES = ROWS * DIGITS;
   localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int ADDR_W  = ROW_W + 3;

   localparam logic [3:0] ROWS_NUM    = 4'(ROWS);
   localparam logic [6:0] ENTRIES_NUM = 7'(ENTRIES);

   localparam logic [7:0] SEG_BLANK = 8'h00;

   localparam logic [7:0] SEG_DIGIT [10] = '{
      8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h67
   };

   // "running." shown after reset
   localparam logic [7:0] SEG_RUNNING [DIGITS] = '{
      8'h50, 8'h1c, 8'h54, 8'h54, 8'h10, 8'h54, 8'h6f, 8'h80
   };

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic [2:0] eighths;
      logic [5:0] seconds;
      logic [5:0] minutes;
      logic [4:0] hours;
   } clock_time_type;

   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [10:0]       wr_data;
   } mem_req_type;

endpackage : csb_pkg
`default_nettype wire

// ===== rtl/csb_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// csb_if: request and response channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ---------------------------------------------------------------------------
interface csb_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [4:0] read_index;

   modport source (output valid, output operation, output read_index, input ready);
   modport sink   (input valid, input operation, input read_index, output ready);
endinterface : csb_req_if

interface csb_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] entry_word;

   modport source (output valid, output entry_word, input ready);
   modport sink   (input valid, input entry_word, output ready);
endinterface : csb_rsp_if
`default_nettype wire

// ===== rtl/csb_time.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// csb_time: time of day counters
// Eighths, seconds, minutes and hours with cascaded wraps.
// ---------------------------------------------------------------------------
module csb_time
   import csb_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      advance,
   output clock_time_type tod
);

   clock_time_type tod_ff, tod_in;

   always_comb begin
      tod_in = tod_ff;
      if (advance) begin
         tod_in.eighths = tod_ff.eighths + 3'd1;
         if (tod_ff.eighths == 3'd7) begin
            if (tod_ff.seconds == 6'd59) begin
               tod_in.seconds = 6'd0;
               if (tod_ff.minutes == 6'd59) begin
                  tod_in.minutes = 6'd0;
                  tod_in.hours   = (tod_ff.hours == 5'd23) ? 5'd0 : tod_ff.hours + 5'd1;
               end else begin
                  tod_in.minutes = tod_ff.minutes + 6'd1;
               end
            end else begin
               tod_in.seconds = tod_ff.seconds + 6'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tod_ff <= '{eighths: 3'd0, seconds: 6'd30, minutes: 6'd6, hours: 5'd12};
      end else begin
         tod_ff <= tod_in;
      end
   end

   assign tod = tod_ff;

endmodule : csb_time
`default_nettype wire

// ===== rtl/csb_seg_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// csb_seg_unit: digit encoder
// Builds the buffer entry for one digit position from the current time.
// ---------------------------------------------------------------------------
module csb_seg_unit
   import csb_pkg::*;
(
   input  wire logic [2:0]     pos,
   input  wire clock_time_type tod,
   output logic      [10:0]    entry
);

   function automatic logic [2:0] tens_of(input logic [5:0] v);
      logic [2:0] t;
      if      (v >= 6'd50) t = 3'd5;
      else if (v >= 6'd40) t = 3'd4;
      else if (v >= 6'd30) t = 3'd3;
      else if (v >= 6'd20) t = 3'd2;
      else if (v >= 6'd10) t = 3'd1;
      else                 t = 3'd0;
      return t;
   endfunction

   logic [5:0] value;
   logic [2:0] tens;
   logic [3:0] ones;
   logic [7:0] code;

   always_comb begin
      case (pos[2:1])
         2'd0:    value = {1'b0, tod.hours};
         2'd1:    value = tod.minutes;
         2'd2:    value = tod.seconds;
         default: value = 6'd0;
      endcase
      tens = tens_of(value);
      ones = 4'(value - 6'(tens) * 6'd10);
      if (pos[2:1] == 2'd3) begin
         code = SEG_BLANK;
      end else if (!pos[0]) begin
         code = SEG_DIGIT[tens];
      end else begin
         code = SEG_DIGIT[ones];
      end
      entry = {pos, code};
   end

endmodule : csb_seg_unit
`default_nettype wire

// ===== rtl/csb_buffer.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// csb_buffer: display buffer memory
// One port, registered read; per-row valid bits stand in for the reset image.
// ---------------------------------------------------------------------------
module csb_buffer
   import csb_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire mem_req_type  mem_req,
   output logic       [10:0] rd_word
);

   logic [10:0] mem [ENTRIES];
   logic        row_valid_ff [ROWS];

   logic [10:0]      rd_data_ff;
   logic             rd_valid_ff;
   logic             rd_row0_ff;
   logic [2:0]       rd_pos_ff;
   logic [ROW_W-1:0] row;

   assign row = mem_req.addr[ADDR_W-1:3];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff  <= mem[mem_req.addr];
         rd_valid_ff <= row_valid_ff[row];
         rd_row0_ff  <= (row == '0);
         rd_pos_ff   <= mem_req.addr[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++) begin
            row_valid_ff[r] <= 1'b0;
         end
      end else if (mem_req.wr_en) begin
         row_valid_ff[row] <= 1'b1;
      end
   end

   // unwritten rows read as their reset image
   always_comb begin
      if (rd_valid_ff) begin
         rd_word = rd_data_ff;
      end else if (rd_row0_ff) begin
         rd_word = {rd_pos_ff, SEG_RUNNING[rd_pos_ff]};
      end else begin
         rd_word = '0;
      end
   end

endmodule : csb_buffer
`default_nettype wire

// ===== rtl/clock_seven_segment_buffer.sv =====
`default_nettype none
// Sequencing: a read goes through the buffer read register, then the output
//   register when free; a tick makes 8 buffer writes, or 16 when row 0 is copied.
// Throughput: one item at a time, bounded by the single buffer write port.
// Reset (sync, active high): time 12:06:30.0, row valid bits cleared so row 0
//   reads "running." and other rows read zero; no clearing pass is needed.
// ---------------------------------------------------------------------------
// clock_seven_segment_buffer: seven segment clock display buffer
// Keeps time of day in eighths of a second and renders HHMMSS into a
// display buffer, row 0 being copied into rows 1..3 on selected eighths.
// ---------------------------------------------------------------------------
module clock_seven_segment_buffer
   import csb_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   csb_req_if.sink    req_chan,
   csb_rsp_if.source  rsp_chan
);

   // sequencer state
   state_type  state_ff, state_in;
   logic [2:0] pos_ff, pos_in;       // digit being written
   logic       phase_ff, phase_in;   // 0: row 0 write, 1: copy-row write
   logic       in_range_ff, in_range_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [10:0] rsp_word_ff;
   logic        rsp_load;

   logic           req_xfer;
   logic           tick_go;
   logic           copy_en;
   logic [10:0]    seg_entry;
   logic [10:0]    rd_word;
   mem_req_type    mem_req;
   clock_time_type tod;

   csb_time u_time (
      .clock   (clock),
      .reset   (reset),
      .advance (tick_go),
      .tod     (tod)
   );

   // shared encoder, stepped over the eight positions
   csb_seg_unit u_seg (
      .pos   (pos_ff),
      .tod   (tod),
      .entry (seg_entry)
   );

   csb_buffer u_buf (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_word (rd_word)
   );

   assign req_chan.ready = (state_ff == ST_IDLE) && !reset;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   // copy target is the new eighth count, if that row exists
   assign copy_en = (tod.eighths >= 3'd1) && (tod.eighths <= 3'd3) &&
                    ({1'b0, tod.eighths} < ROWS_NUM);

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      phase_in    = phase_ff;
      in_range_in = in_range_ff;
      tick_go     = 1'b0;
      rsp_load    = 1'b0;
      mem_req     = '{wr_en: 1'b0, rd_en: 1'b0, addr: '0, wr_data: seg_entry};

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (op_type'(req_chan.operation) == OP_READ) begin
                  mem_req.rd_en = 1'b1;
                  mem_req.addr  = ADDR_W'(req_chan.read_index);
                  in_range_in   = ({2'b00, req_chan.read_index} < ENTRIES_NUM);
                  state_in      = ST_READ;
               end else begin
                  tick_go  = 1'b1;
                  pos_in   = 3'd0;
                  phase_in = 1'b0;
                  state_in = ST_WRITE;
               end
            end
         end
         ST_READ: begin
            // wait for a free output slot
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_WRITE: begin
            mem_req.wr_en = 1'b1;
            if (phase_ff) begin
               mem_req.addr = {tod.eighths[ROW_W-1:0], pos_ff};
            end else begin
               mem_req.addr = {ROW_W'(0), pos_ff};
            end
            if (!phase_ff && copy_en) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               pos_in   = pos_ff + 3'd1;
               if (pos_ff == 3'd7) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= 3'd0;
         phase_ff     <= 1'b0;
         in_range_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         in_range_ff  <= in_range_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_word_ff <= in_range_ff ? rd_word : 11'd0;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.entry_word = rsp_word_ff;

   // a tick transfer starts the write sweep at position 0, row 0
   a_tick_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      tick_go |=> (state_ff == ST_WRITE) && (pos_ff == 3'd0) && !phase_ff)
      else $error("tick did not start write sweep");

   // the clock only moves on a tick transfer
   a_time_stable: assert property (@(posedge clock) disable iff (reset)
      !tick_go |=> $stable(tod))
      else $error("time changed without a tick");

   // copy phase only happens for a row that is copied
   a_copy_phase: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) && phase_ff |-> copy_en && $past(!phase_ff))
      else $error("copy phase without copy target");

   // while a read waits in ST_READ, no request is accepted and the buffer is not written
   a_read_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !req_chan.ready && !mem_req.wr_en)
      else $error("buffer busy during read");

endmodule : clock_seven_segment_buffer
`default_nettype wire
